[design/cross_stamp_coverage_core_defines.svh]
// assertion macros for the cross stamp coverage core
// depends on nothing; included by the top level only
`ifndef CROSS_STAMP_COVERAGE_CORE_DEFINES_SVH
`define CROSS_STAMP_COVERAGE_CORE_DEFINES_SVH

// same-cycle implication, async active-low reset
`define CSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("csc assertion failed");

// next-cycle implication, async active-low reset
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("csc assertion failed");

`endif

[design/csc_pkg.sv]
// shared types and constants for the cross stamp coverage core
// depends on nothing
`timescale 1ns / 1ps

package csc_pkg;

	// request payload
	typedef struct packed {
		logic [9:0] center_x;
		logic [9:0] center_y;
	} in_t;

	// result payload
	typedef struct packed {
		logic [2:0]  newly_covered;
		logic [16:0] covered_total;
		logic        canvas_full;
	} out_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN
	} state_t;

	// register indexes
	localparam logic CFG_CANVAS_WIDTH  = 1'b0;
	localparam logic CFG_CANVAS_HEIGHT = 1'b1;

	localparam logic [8:0] CANVAS_RESET = 9'd256;

	// five cells per stamp, one extra step drains the last write
	localparam logic [2:0] LAST_STEP = 3'd5;

	// column offset of each stamp cell: center, right, left, down, up
	function automatic logic [1:0] cell_dx(input logic [2:0] step);
		logic [1:0] d;
		case (step)
			3'd1:    d = 2'b01;
			3'd2:    d = 2'b11;
			default: d = 2'b00;
		endcase
		return d;
	endfunction

	// row offset of each stamp cell
	function automatic logic [1:0] cell_dy(input logic [2:0] step);
		logic [1:0] d;
		case (step)
			3'd3:    d = 2'b01;
			3'd4:    d = 2'b11;
			default: d = 2'b00;
		endcase
		return d;
	endfunction

endpackage

[design/csc_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module csc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[design/cross_stamp_coverage_core.sv]
// cross stamp coverage core: each accepted request yields one done strobe with its result
// each request takes five bitmap read-modify-writes through one ram
// port plus one drain step; the next start is taken in the cycle of the last write
// reset clears the bitmap in a pass over all MAX_WIDTH*MAX_HEIGHT cells, busy stays high
// meanwhile; config writes are taken at any time; the receiver cannot stall results
// depends on csc_pkg, csc_ram and cross_stamp_coverage_core_defines.svh
`timescale 1ns / 1ps
`include "cross_stamp_coverage_core_defines.svh"

module cross_stamp_coverage_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  csc_pkg::in_t  req,
	output logic          done,
	output csc_pkg::out_t result,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [8:0]    cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EFF_W = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
	localparam int EFF_H = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
	localparam int CNT_W = $clog2(EFF_W * EFF_H + 1);

	csc_pkg::state_t state_q, state_nx;

	logic [8:0]       width_q, height_q;
	logic [8:0]       w_eff, h_eff;
	csc_pkg::in_t     center_q;
	logic [2:0]       step_q;
	logic             proc_valid_q;
	logic [AW-1:0]    proc_addr_q;
	logic [2:0]       fresh_q;
	logic [CNT_W-1:0] count_q;
	logic [17:0]      area_q;
	logic [AW-1:0]    clr_q;
	csc_pkg::out_t    result_q;
	logic             done_q;

	logic             accept;
	logic             issue;
	logic             last_step;
	logic [1:0]       dx, dy;
	logic [10:0]      cx, cy, cx_m1, cy_m1;
	logic             cell_ok;
	logic [AW-1:0]    cell_addr;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic             ram_wdata;
	logic             ram_rdata;
	logic             newbit;
	logic [2:0]       fresh_nx;
	logic [CNT_W-1:0] count_nx;
	logic [17:0]      count_ext;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= csc_pkg::CANVAS_RESET;
			height_q <= csc_pkg::CANVAS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				csc_pkg::CFG_CANVAS_WIDTH:  width_q  <= cfg_data;
				csc_pkg::CFG_CANVAS_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate canvas size to the bitmap size
	always_comb begin
		w_eff = ({4'b0, width_q} > 13'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_q;
		h_eff = ({4'b0, height_q} > 13'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_q;
	end

	assign last_step = (step_q == csc_pkg::LAST_STEP);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			csc_pkg::ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) state_nx = csc_pkg::ST_IDLE;
			end
			csc_pkg::ST_IDLE: begin
				if (start) state_nx = csc_pkg::ST_RUN;
			end
			csc_pkg::ST_RUN: begin
				if (last_step && !start) state_nx = csc_pkg::ST_IDLE;
			end
			default: state_nx = csc_pkg::ST_CLEAR;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy  = 1'b1;
		issue = 1'b0;
		case (state_q)
			csc_pkg::ST_CLEAR: busy = 1'b1;
			csc_pkg::ST_IDLE:  busy = 1'b0;
			csc_pkg::ST_RUN: begin
				busy  = !last_step;
				issue = !last_step;
			end
			default: busy = 1'b1;
		endcase
	end

	assign accept = start && !busy;

	// clip the current stamp cell and form its bitmap address
	always_comb begin
		dx    = csc_pkg::cell_dx(step_q);
		dy    = csc_pkg::cell_dy(step_q);
		cx    = 11'(center_q.center_x) + {{9{dx[1]}}, dx};
		cy    = 11'(center_q.center_y) + {{9{dy[1]}}, dy};
		cx_m1 = cx - 11'd1;
		cy_m1 = cy - 11'd1;
		cell_ok = (cx != 11'd0) && (cx <= 11'(w_eff)) &&
			(cy != 11'd0) && (cy <= 11'(h_eff));
		cell_addr = AW'(AW'(cy_m1[8:0]) * AW'(MAX_WIDTH) + AW'(cx_m1[8:0]));
	end

	// write side: clearing pass or setting a newly covered bit
	always_comb begin
		newbit    = (state_q == csc_pkg::ST_RUN) && proc_valid_q && !ram_rdata;
		ram_we    = (state_q == csc_pkg::ST_CLEAR) || newbit;
		ram_waddr = (state_q == csc_pkg::ST_CLEAR) ? clr_q : proc_addr_q;
		ram_wdata = (state_q != csc_pkg::ST_CLEAR);
		fresh_nx  = fresh_q + 3'(newbit);
		count_nx  = count_q + CNT_W'(newbit);
		count_ext = 18'(count_nx);
	end

	csc_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cell_addr),
		.rdata (ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= csc_pkg::ST_CLEAR;
			clr_q        <= '0;
			step_q       <= 3'd0;
			proc_valid_q <= 1'b0;
			fresh_q      <= 3'd0;
			count_q      <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == csc_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			count_q <= count_nx;
			done_q  <= (state_q == csc_pkg::ST_RUN) && last_step;
			if (accept) begin
				step_q       <= 3'd0;
				proc_valid_q <= 1'b0;
				fresh_q      <= 3'd0;
			end else begin
				if (issue) step_q <= step_q + 3'd1;
				proc_valid_q <= issue && cell_ok;
				fresh_q      <= fresh_nx;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			center_q <= req;
			area_q   <= 18'(w_eff) * 18'(h_eff);
		end
		if (issue) proc_addr_q <= cell_addr;
		if ((state_q == csc_pkg::ST_RUN) && last_step) begin
			result_q.newly_covered <= fresh_nx;
			result_q.covered_total <= count_ext[16:0];
			result_q.canvas_full   <= (count_ext == area_q);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// accepted request keeps the block busy
	`CSC_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// results are single-cycle pulses, at most one per request
	`CSC_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	// a stamp covers at most five cells
	`CSC_ASSERT_NOW(a_newly_range, clk, arst_n, done, result.newly_covered <= 3'd5)

endmodule

[bench/tb_top.sv]
// self-checking bench for cross_stamp_coverage_core: directed and random stamps on a range of
// canvas sizes, every result checked against a bitmap predictor kept in the bench
// depends on csc_pkg and the cross_stamp_coverage_core rtl
`timescale 1ns / 1ps

module tb_top;

	localparam int MAP_W      = 256;
	localparam int MAP_H      = 256;
	localparam int MAP_CELLS  = MAP_W * MAP_H;
	localparam int IDLE_LIMIT = 200000;
	localparam int SHOW_LIMIT = 10;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	csc_pkg::in_t  req = '0;
	logic          done;
	csc_pkg::out_t result;
	logic          cfg_we = 1'b0;
	logic          cfg_index = csc_pkg::CFG_CANVAS_WIDTH;
	logic [8:0]    cfg_data = '0;

	// predictor state: canvas registers, cell bitmap and distinct cell count
	logic [8:0]  canvas_w = csc_pkg::CANVAS_RESET;
	logic [8:0]  canvas_h = csc_pkg::CANVAS_RESET;
	bit          coverage_bits [0:MAP_CELLS-1];
	int unsigned covered_cells = 0;

	csc_pkg::out_t stamp_results_due [$];
	int            mismatches = 0;
	int            idle_cycles = 0;

	cross_stamp_coverage_core #(
		.MAX_WIDTH(MAP_W),
		.MAX_HEIGHT(MAP_H)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// saturated canvas dimensions
	function automatic int eff_w();
		return (canvas_w > MAP_W) ? MAP_W : int'(canvas_w);
	endfunction

	function automatic int eff_h();
		return (canvas_h > MAP_H) ? MAP_H : int'(canvas_h);
	endfunction

	// set one cell if it is on the canvas, 1 when it was not set yet
	function automatic int unsigned mark_cell(int cx, int cy, int w, int h);
		int idx;
		if (cx < 1 || cy < 1 || cx > w || cy > h)
			return 0;
		idx = (cy - 1) * MAP_W + (cx - 1);
		if (coverage_bits[idx])
			return 0;
		coverage_bits[idx] = 1'b1;
		covered_cells++;
		return 1;
	endfunction

	// apply one stamp to the predictor and build the result it must give
	function automatic csc_pkg::out_t predict_stamp(csc_pkg::in_t r);
		int            x;
		int            y;
		int            w;
		int            h;
		int unsigned   fresh;
		csc_pkg::out_t o;
		x = int'(r.center_x);
		y = int'(r.center_y);
		w = eff_w();
		h = eff_h();
		fresh = mark_cell(x, y, w, h);
		fresh += mark_cell(x + 1, y, w, h);
		fresh += mark_cell(x - 1, y, w, h);
		fresh += mark_cell(x, y + 1, w, h);
		fresh += mark_cell(x, y - 1, w, h);
		o.newly_covered = fresh[2:0];
		o.covered_total = covered_cells[16:0];
		o.canvas_full   = (covered_cells == w * h);
		return o;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// coordinate near the canvas most of the time, anywhere in the field otherwise
	function automatic logic [9:0] pick_coord(int span);
		if ($urandom_range(0, 4) == 0)
			return 10'($urandom_range(0, 1023));
		return 10'($urandom_range(0, span + 1));
	endfunction

	// issue one request and record its expected result once it is taken
	task automatic send_stamp(input logic [9:0] cx, input logic [9:0] cy, input int gap);
		csc_pkg::in_t  r;
		csc_pkg::out_t want;
		r.center_x = cx;
		r.center_y = cy;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		req   <= r;
		do begin
			@(posedge clk);
		end while (busy);
		want = predict_stamp(r);
		stamp_results_due = {stamp_results_due, want};
	endtask

	// drop start and wait until every result is back
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (stamp_results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [8:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == csc_pkg::CFG_CANVAS_WIDTH)
			canvas_w = data;
		else
			canvas_h = data;
	endtask

	task automatic set_canvas(input logic [8:0] w, input logic [8:0] h);
		wait_drained();
		write_reg(csc_pkg::CFG_CANVAS_WIDTH, w);
		write_reg(csc_pkg::CFG_CANVAS_HEIGHT, h);
	endtask

	// zero width or height: nothing is marked, full flag compares against zero
	task automatic test_empty_canvas();
		set_canvas(9'd0, 9'd256);
		send_stamp(10'd1, 10'd1, pick_gap());
		send_stamp(10'd0, 10'd0, pick_gap());
		set_canvas(9'd256, 9'd0);
		send_stamp(10'd5, 10'd5, pick_gap());
	endtask

	// one cell canvas, stamp outside, then the single cell twice
	task automatic test_unit_canvas();
		set_canvas(9'd1, 9'd1);
		send_stamp(10'd0, 10'd0, pick_gap());
		send_stamp(10'd1, 10'd1, pick_gap());
		send_stamp(10'd1, 10'd1, pick_gap());
	endtask

	// grow to 3x2 with the earlier cell kept and cover it completely
	task automatic test_fill_small_canvas();
		set_canvas(9'd3, 9'd2);
		send_stamp(10'd2, 10'd1, pick_gap());
		send_stamp(10'd1, 10'd2, pick_gap());
		send_stamp(10'd3, 10'd2, pick_gap());
		send_stamp(10'd2, 10'd2, pick_gap());
	endtask

	// oversize registers saturate; corners, field extremes and alternating bits
	task automatic test_edges_oversize();
		set_canvas(9'd511, 9'd300);
		send_stamp(10'd1023, 10'd1023, pick_gap());
		send_stamp(10'd256, 10'd256, pick_gap());
		send_stamp(10'd257, 10'd256, pick_gap());
		send_stamp(10'd0, 10'd0, pick_gap());
		send_stamp(10'd1023, 10'd0, pick_gap());
		send_stamp(10'd0, 10'd1023, pick_gap());
		set_canvas(9'd257, 9'd257);
		send_stamp(10'd256, 10'd1, pick_gap());
		send_stamp(10'd1, 10'd256, pick_gap());
		send_stamp(10'h155, 10'h2aa, pick_gap());
		send_stamp(10'h2aa, 10'h155, pick_gap());
	endtask

	// random stamps over a sequence of canvas settings
	task automatic test_random_stamps();
		int         p;
		int         n;
		bit         no_idle;
		logic [8:0] w;
		logic [8:0] h;
		for (p = 0; p < 8; p++) begin
			case (p)
				0: begin w = 9'd256; h = 9'd256; end
				1: begin w = 9'd511; h = 9'd511; end
				2: begin w = 9'd0; h = 9'($urandom_range(0, 511)); end
				3: begin w = 9'd1; h = 9'($urandom_range(1, 511)); end
				4: begin w = 9'($urandom_range(1, 511)); h = 9'd1; end
				default: begin
					if ($urandom_range(0, 1) == 0) begin
						w = 9'($urandom_range(1, 16));
						h = 9'($urandom_range(1, 16));
					end else begin
						w = 9'($urandom_range(0, 511));
						h = 9'($urandom_range(0, 511));
					end
				end
			endcase
			set_canvas(w, h);
			no_idle = (p % 3 == 2);
			for (n = 0; n < 100; n++)
				send_stamp(pick_coord(eff_w()), pick_coord(eff_h()), no_idle ? 0 : pick_gap());
		end
	endtask

	// result checker against the oldest expectation
	always @(posedge clk) begin
		csc_pkg::out_t want;
		if (arst_n && done) begin
			if (stamp_results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("unexpected result %0d %0d %0d", result.newly_covered,
						result.covered_total, result.canvas_full);
			end else begin
				want = stamp_results_due.pop_front();
				if (result.newly_covered !== want.newly_covered) begin
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display("newly_covered: expected %0d, got %0d",
							want.newly_covered, result.newly_covered);
				end
				if (result.covered_total !== want.covered_total) begin
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display("covered_total: expected %0d, got %0d",
							want.covered_total, result.covered_total);
				end
				if (result.canvas_full !== want.canvas_full) begin
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display("canvas_full: expected %0d, got %0d",
							want.canvas_full, result.canvas_full);
				end
			end
		end
	end

	// watchdog on cycles with neither a request taken nor a result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		test_empty_canvas();
		test_unit_canvas();
		test_fill_small_canvas();
		test_edges_oversize();
		test_random_stamps();
		wait_drained();
		repeat (20) @(posedge clk);
		if (stamp_results_due.size() != 0)
			$display("%0d results never arrived", stamp_results_due.size());
		if (mismatches == 0 && stamp_results_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/csc_pkg.sv
design/csc_ram.sv
design/cross_stamp_coverage_core.sv
bench/tb_top.sv
